FILE: rtl/sip_pkg.sv
// Shared definitions for the segment intersection point block.
// Holds the status codes and default coordinate width; no dependencies.
package sip_pkg;

    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_HIT       = 2'd1,
        ST_COLLINEAR = 2'd2
    } sip_status_t;

endpackage

FILE: rtl/segment_intersection_point.sv
// Top level of the segment intersection point block.
// Depends on sip_pkg and instantiates two sip_div dividers.
//
// Each transfer on the input channel carries two segments, A-B and C-D. The block
// takes one transfer per clock while in_stall is low and returns exactly one
// result transfer per input, in order, through four arithmetic stages (line
// coefficients, line products, side tests with the determinant and numerator
// partial products, numerator assembly), then the dividers, which resolve one
// quotient bit per stage after a rounding stage, and a final output register.
// The whole pipeline advances together; while a finished result waits on a
// stalled output, in_stall is raised and every stage holds. status reads 0 when
// one segment lies strictly on one side of the other line, 2 when neither does
// but the determinant is zero (collinear or degenerate segments), and 1 with the
// rounded crossing point otherwise; hit_x and hit_y read 0 unless status is 1.
module segment_intersection_point #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by_coord,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] dx,
    input  logic signed [COORD_BITS-1:0] dy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic signed [COORD_BITS-1:0] hit_x,
    output logic signed [COORD_BITS-1:0] hit_y
);
    import sip_pkg::*;

    localparam int N     = COORD_BITS;
    localparam int E_W   = N + 1;
    localparam int P_W   = 2 * N;
    localparam int C_W   = 2 * N + 1;
    localparam int PP_W  = 2 * N + 2;
    localparam int S_W   = 2 * N + 3;
    localparam int DT_W  = 2 * N + 3;
    localparam int NM_W  = 3 * N + 3;

    // The pipeline moves whenever the output register is free or being taken.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Stage 1: line coefficients and the corner products for c.
    logic                  s1_valid_reg;
    logic signed [N-1:0]   x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic signed [E_W-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [P_W-1:0] p21_reg, p12_reg, p43_reg, p34_reg;

    // Stage 2: c terms, end point products and determinant products.
    logic                   s2_valid_reg;
    logic signed [E_W-1:0]  a1_s2_reg, b1_s2_reg, a2_s2_reg, b2_s2_reg;
    logic signed [C_W-1:0]  c1_reg, c2_reg;
    logic signed [C_W-1:0]  q1_reg, r1_reg, q2_reg, r2_reg, q3_reg, r3_reg, q4_reg, r4_reg;
    logic signed [PP_W-1:0] dp1_reg, dp2_reg;

    // Stage 3: status, determinant and numerator partial products.
    logic                   s3_valid_reg;
    sip_status_t            s3_status_reg;
    logic signed [DT_W-1:0] s3_det_reg;
    logic signed [PP_W-1:0] bc2_hi_reg, bc2_lo_reg, bc1_hi_reg, bc1_lo_reg;
    logic signed [PP_W-1:0] ac1_hi_reg, ac1_lo_reg, ac2_hi_reg, ac2_lo_reg;

    // Stage 4: full numerators.
    logic                   s4_valid_reg;
    sip_status_t            s4_status_reg;
    logic signed [DT_W-1:0] s4_det_reg;
    logic signed [NM_W-1:0] nx_reg, ny_reg;

    // Delay line beside the dividers.
    logic        v_line_reg  [0:N];
    sip_status_t st_line_reg [0:N];

    logic signed [N-1:0] qx, qy;

    sip_status_t         status_reg;
    logic                out_valid_reg;
    logic signed [N-1:0] hit_x_reg, hit_y_reg;

    logic signed [S_W-1:0]  sv1, sv2, sv3, sv4;
    logic signed [DT_W-1:0] det_next;
    sip_status_t            status_next;

    function automatic logic same_side(input logic signed [S_W-1:0] u,
                                       input logic signed [S_W-1:0] v);
        return (u != '0) && (v != '0) && (u[S_W-1] == v[S_W-1]);
    endfunction

    function automatic logic signed [NM_W-1:0] join_pp(input logic signed [PP_W-1:0] hi,
                                                       input logic signed [PP_W-1:0] lo);
        return (NM_W'(hi) <<< N) + NM_W'(lo);
    endfunction

    function automatic logic signed [E_W-1:0] low_part(input logic signed [C_W-1:0] c);
        return $signed({1'b0, c[N-1:0]});
    endfunction

    function automatic logic signed [E_W-1:0] high_part(input logic signed [C_W-1:0] c);
        return $signed(c[C_W-1:N]);
    endfunction

    always_comb
    begin
        sv1 = S_W'(q1_reg) + S_W'(r1_reg) + S_W'(c1_reg);
        sv2 = S_W'(q2_reg) + S_W'(r2_reg) + S_W'(c1_reg);
        sv3 = S_W'(q3_reg) + S_W'(r3_reg) + S_W'(c2_reg);
        sv4 = S_W'(q4_reg) + S_W'(r4_reg) + S_W'(c2_reg);
        det_next = DT_W'(dp1_reg) - DT_W'(dp2_reg);
        if (same_side(sv1, sv2) || same_side(sv3, sv4))
            status_next = ST_NONE;
        else if (det_next == '0)
            status_next = ST_COLLINEAR;
        else
            status_next = ST_HIT;
    end

    // Control state: valid bits, reset asynchronously.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
                v_line_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            v_line_reg[0] <= s4_valid_reg;
            for (int i = 1; i <= N; i++)
                v_line_reg[i] <= v_line_reg[i-1];
            out_valid_reg <= v_line_reg[N];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= ax;
            y1_reg  <= ay;
            x2_reg  <= bx;
            y2_reg  <= by_coord;
            x3_reg  <= cx;
            y3_reg  <= cy;
            x4_reg  <= dx;
            y4_reg  <= dy;
            a1_reg  <= E_W'(by_coord) - E_W'(ay);
            b1_reg  <= E_W'(ax) - E_W'(bx);
            a2_reg  <= E_W'(dy) - E_W'(cy);
            b2_reg  <= E_W'(cx) - E_W'(dx);
            p21_reg <= P_W'(bx) * P_W'(ay);
            p12_reg <= P_W'(ax) * P_W'(by_coord);
            p43_reg <= P_W'(dx) * P_W'(cy);
            p34_reg <= P_W'(cx) * P_W'(dy);

            a1_s2_reg <= a1_reg;
            b1_s2_reg <= b1_reg;
            a2_s2_reg <= a2_reg;
            b2_s2_reg <= b2_reg;
            c1_reg    <= C_W'(p21_reg) - C_W'(p12_reg);
            c2_reg    <= C_W'(p43_reg) - C_W'(p34_reg);
            q1_reg    <= C_W'(a1_reg) * C_W'(x3_reg);
            r1_reg    <= C_W'(b1_reg) * C_W'(y3_reg);
            q2_reg    <= C_W'(a1_reg) * C_W'(x4_reg);
            r2_reg    <= C_W'(b1_reg) * C_W'(y4_reg);
            q3_reg    <= C_W'(a2_reg) * C_W'(x1_reg);
            r3_reg    <= C_W'(b2_reg) * C_W'(y1_reg);
            q4_reg    <= C_W'(a2_reg) * C_W'(x2_reg);
            r4_reg    <= C_W'(b2_reg) * C_W'(y2_reg);
            dp1_reg   <= PP_W'(a1_reg) * PP_W'(b2_reg);
            dp2_reg   <= PP_W'(a2_reg) * PP_W'(b1_reg);

            s3_status_reg <= status_next;
            s3_det_reg    <= det_next;
            bc2_hi_reg <= PP_W'(b1_s2_reg) * PP_W'(high_part(c2_reg));
            bc2_lo_reg <= PP_W'(b1_s2_reg) * PP_W'(low_part(c2_reg));
            bc1_hi_reg <= PP_W'(b2_s2_reg) * PP_W'(high_part(c1_reg));
            bc1_lo_reg <= PP_W'(b2_s2_reg) * PP_W'(low_part(c1_reg));
            ac1_hi_reg <= PP_W'(a2_s2_reg) * PP_W'(high_part(c1_reg));
            ac1_lo_reg <= PP_W'(a2_s2_reg) * PP_W'(low_part(c1_reg));
            ac2_hi_reg <= PP_W'(a1_s2_reg) * PP_W'(high_part(c2_reg));
            ac2_lo_reg <= PP_W'(a1_s2_reg) * PP_W'(low_part(c2_reg));

            s4_status_reg <= s3_status_reg;
            s4_det_reg    <= s3_det_reg;
            nx_reg <= join_pp(bc2_hi_reg, bc2_lo_reg) - join_pp(bc1_hi_reg, bc1_lo_reg);
            ny_reg <= join_pp(ac1_hi_reg, ac1_lo_reg) - join_pp(ac2_hi_reg, ac2_lo_reg);

            st_line_reg[0] <= s4_status_reg;
            for (int i = 1; i <= N; i++)
                st_line_reg[i] <= st_line_reg[i-1];

            status_reg <= st_line_reg[N];
            hit_x_reg  <= (st_line_reg[N] == ST_HIT) ? qx : '0;
            hit_y_reg  <= (st_line_reg[N] == ST_HIT) ? qy : '0;
        end
    end

    sip_div #(
        .NUM_W (NM_W),
        .DEN_W (DT_W),
        .Q_W   (N)
    ) u_div_x (
        .clk (clk),
        .adv (adv),
        .num (nx_reg),
        .den (s4_det_reg),
        .quo (qx)
    );

    sip_div #(
        .NUM_W (NM_W),
        .DEN_W (DT_W),
        .Q_W   (N)
    ) u_div_y (
        .clk (clk),
        .adv (adv),
        .num (ny_reg),
        .den (s4_det_reg),
        .quo (qy)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;

`ifndef SYNTH
    // A result without a crossing point carries a zero point.
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_HIT) |-> (hit_x == '0) && (hit_y == '0))
        else $error("non-hit result carries a nonzero point");

    // A held output freezes the whole pipeline, input side included.
    a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output held");

    // Every accepted transfer enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted transfer lost at first stage");
`endif

endmodule

FILE: rtl/sip_div.sv
// Pipelined rounding divider: one quotient bit per register stage.
// Depends on sip_pkg; instantiated by segment_intersection_point.
module sip_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 35,
    parameter int Q_W   = 16
) (
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [Q_W-1:0]   quo
);
    import sip_pkg::*;

    localparam int M_W = NUM_W + 1;
    localparam int CW  = (M_W > DEN_W + Q_W) ? M_W : DEN_W + Q_W;

    logic [M_W-1:0]   rem_reg [0:Q_W];
    logic [DEN_W-1:0] d_reg   [0:Q_W];
    logic             neg_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [M_W-1:0]   rem_next;

    // Magnitudes with half the divisor added, so that truncation rounds half away from zero.
    always_comb
    begin
        num_mag  = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
        den_mag  = den[DEN_W-1] ? (~den + DEN_W'(1)) : den;
        rem_next = M_W'(num_mag) + M_W'(den_mag >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem_next;
            d_reg[0]   <= den_mag;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [CW-1:0] shd;
        logic [CW-1:0] cur;
        logic [CW-1:0] diff;
        logic          ge;

        always_comb
        begin
            shd  = CW'(d_reg[k]) << B;
            cur  = CW'(rem_reg[k]);
            ge   = (cur >= shd);
            diff = cur - shd;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= ge ? M_W'(diff) : rem_reg[k];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                q_reg[k+1]   <= q_reg[k] | (Q_W'(ge) << B);
            end
        end
    end

    assign quo = neg_reg[Q_W] ? $signed(Q_W'(~q_reg[Q_W]) + Q_W'(1)) : $signed(q_reg[Q_W]);

endmodule

FILE: verif/segment_intersection_point_checker.sv
// Checker for the segment intersection point block: watches both channels,
// predicts each result and compares it field by field. Depends on sip_pkg.
module segment_intersection_point_checker #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by_coord,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] dx,
    input  logic signed [COORD_BITS-1:0] dy,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [1:0]                   status,
    input  logic signed [COORD_BITS-1:0] hit_x,
    input  logic signed [COORD_BITS-1:0] hit_y,
    output int                           fail_count,
    output int                           pending
);
    import sip_pkg::*;

    typedef struct packed {
        sip_status_t                  st;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } crossing_t;

    crossing_t crossings_due[$];

    function automatic logic signed [COORD_BITS-1:0] round_quot(
        longint signed num, longint signed den);
        longint signed mag;
        longint signed q;
        mag = (num < 0) ? -num : num;
        mag = mag + ((den < 0 ? -den : den) / 2);
        q = mag / (den < 0 ? -den : den);
        if ((num < 0) != (den < 0))
            q = -q;
        return q[COORD_BITS-1:0];
    endfunction

    function automatic logic opposite_free(longint signed u, longint signed v);
        return u != 0 && v != 0 && ((u < 0) == (v < 0));
    endfunction

    function automatic crossing_t predict_crossing(
        longint signed x1, longint signed y1, longint signed x2, longint signed y2,
        longint signed x3, longint signed y3, longint signed x4, longint signed y4);
        crossing_t r;
        longint signed a1, b1, c1, a2, b2, c2, det;
        r = '{ST_NONE, '0, '0};
        a1 = y2 - y1;
        b1 = x1 - x2;
        c1 = x2 * y1 - x1 * y2;
        a2 = y4 - y3;
        b2 = x3 - x4;
        c2 = x4 * y3 - x3 * y4;
        if (opposite_free(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1))
            return r;
        if (opposite_free(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2))
            return r;
        det = a1 * b2 - a2 * b1;
        if (det == 0)
        begin
            r.st = ST_COLLINEAR;
            return r;
        end
        // For 16-bit coordinates the numerators stay well inside 64 bits.
        r.st = ST_HIT;
        r.px = round_quot(b1 * c2 - b2 * c1, det);
        r.py = round_quot(a2 * c1 - a1 * c2, det);
        return r;
    endfunction

    assign pending = crossings_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t exp_r;
        if (!rst_n)
        begin
            fail_count = 0;
            crossings_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (crossings_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = crossings_due.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $error("status expected %0d got %0d", exp_r.st, status);
                        fail_count++;
                    end
                    if (hit_x !== exp_r.px)
                    begin
                        $error("hit_x expected %0d got %0d", exp_r.px, hit_x);
                        fail_count++;
                    end
                    if (hit_y !== exp_r.py)
                    begin
                        $error("hit_y expected %0d got %0d", exp_r.py, hit_y);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                crossings_due.push_back(predict_crossing(ax, ay, bx, by_coord,
                                                         cx, cy, dx, dy));
        end
    end
endmodule

FILE: verif/segment_intersection_point_tb.sv
// Testbench top for the segment intersection point block: drives segment
// pairs and gives the verdict. Depends on sip_pkg, the block and its checker.
module segment_intersection_point_tb;
    localparam int CB = 16;
    localparam int RANDOM_PAIRS = 540;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CB-1:0] ax, ay, bx, by_coord, cx, cy, dx, dy;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic signed [CB-1:0] hit_x, hit_y;
    int fail_count;
    int pending;
    logic sender_done;

    segment_intersection_point #(.COORD_BITS(CB)) i_dut (.*);
    segment_intersection_point_checker #(.COORD_BITS(CB)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver stalls on its own pattern: quiet spells, heavy spells,
    // and runs where it never stalls at all.
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 31) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // One transfer: the payload is held until the block takes it. The valid is
    // left high here, so back-to-back transfers never drop it within a step.
    task automatic send_pair(input logic [CB-1:0] p0, p1, p2, p3, p4, p5, p6, p7);
        in_valid <= 1'b1;
        ax <= p0; ay <= p1; bx <= p2; by_coord <= p3;
        cx <= p4; cy <= p5; dx <= p6; dy <= p7;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [CB-1:0] rand_coord(input int span);
        case (span)
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return CB'($signed($urandom_range(0, 40)) - 20);
            2: return CB'($signed($urandom_range(0, 2000)) - 1000);
            default: return CB'($urandom);
        endcase
    endfunction

    initial
    begin
        int burst;
        int span;
        logic [CB-1:0] p [8];
        rst_n = 1'b0;
        in_valid = 1'b0;
        sender_done = 1'b0;
        {ax, ay, bx, by_coord, cx, cy, dx, dy} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs: crossing, touching, separate, parallel, coincident,
        // degenerate points, and the extremes of the coordinate range.
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 0, 5, 0, 5, 9);
        send_pair(0, 0, 10, 0, 0, 5, 10, 7);
        send_pair(0, 0, 10, 0, 0, 3, 10, 3);
        send_pair(0, 0, 10, 10, 2, 2, 20, 20);
        send_pair(4, 4, 4, 4, 4, 4, 4, 4);
        send_pair(1, 1, 1, 1, 0, 0, 5, 5);
        send_pair(0, 0, 3, 1, 0, 1, 3, 0);
        send_pair(0, 0, -3, 1, 0, 1, -3, 0);
        send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7ffe);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                  16'sh8000, 0, 16'sh7fff, 1);
        send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_pair(16'hffff, 16'haaaa, 16'h5555, 0, 16'h0f0f, 16'hf0f0, 16'hffff, 16'h1234);

        // Random pairs in bursts; outside the extreme span, half the time A mirrors B through
        // the origin and D is the bitwise inverse of C, so they tend to cross near it.
        for (int n = 0; n < RANDOM_PAIRS; )
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && n < RANDOM_PAIRS; k++, n++)
            begin
                span = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
                foreach (p[i])
                    p[i] = (span == 0 && $urandom_range(0, 1)) ? rand_coord(3)
                                                              : rand_coord(span);
                if ($urandom_range(0, 1) && span != 0)
                begin
                    p[6] = p[4] ^ {CB{1'b1}};
                    p[7] = p[5] ^ {CB{1'b1}};
                    p[0] = -p[2];
                    p[1] = -p[3];
                end
                send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // Wait for a clock edge after the last transfer so that the checker has queued it.
    initial
    begin
        wait (sender_done);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (CB + 10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: segment_intersection_point.f
rtl/sip_pkg.sv
rtl/sip_div.sv
rtl/segment_intersection_point.sv
verif/segment_intersection_point_checker.sv
verif/segment_intersection_point_tb.sv
